// ===== rtl/core/dvfs_pick_pkg.sv =====
// Package: shared constants, register indexes and widths for the DVFS level / SRTF pick block.
`default_nettype none
package dvfs_pick_pkg;

    // Decision size limit and derived widths
    localparam int MAX_ENTRIES = 16;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SLOT_W      = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;

    // Field widths
    localparam int REM_W    = 26;
    localparam int PCT_W    = 7;
    localparam int LEVEL_W  = 3;
    localparam int OSLOT_W  = 4;
    localparam int SUM_W    = REM_W + $clog2(MAX_ENTRIES);
    localparam int CFG_W    = 26;
    localparam int CFG_IX_W = 3;

    // Comparison widths
    localparam int SUM100_W = SUM_W + 7;
    localparam int UTIL_W   = PCT_W + REM_W;
    localparam int LONG_W   = REM_W + CNT_W;
    localparam int SC_W     = CNT_W + 3;

    // Register indexes
    typedef enum logic [CFG_IX_W-1:0] {
        CFG_SHORT_THR = 3'd0,
        CFG_UTIL_THR  = 3'd1,
        CFG_LONG_THR  = 3'd2,
        CFG_WINDOW    = 3'd3,
        CFG_TOP_LEVEL = 3'd4
    } cfg_index_t;

    // Register reset values
    localparam logic [REM_W-1:0]   SHORT_THR_RST = REM_W'(30000);
    localparam logic [PCT_W-1:0]   UTIL_THR_RST  = PCT_W'(60);
    localparam logic [REM_W-1:0]   LONG_THR_RST  = REM_W'(200000);
    localparam logic [REM_W-1:0]   WINDOW_RST    = REM_W'(200000);
    localparam logic [LEVEL_W-1:0] TOP_LEVEL_RST = LEVEL_W'(2);

    // Window floor and utilization cap
    localparam logic [REM_W-1:0] WINDOW_MIN = REM_W'(1000);
    localparam logic [PCT_W-1:0] PCT_FULL   = PCT_W'(100);

    // Fixed levels
    localparam logic [LEVEL_W-1:0] LEVEL_LOW = LEVEL_W'(0);
    localparam logic [LEVEL_W-1:0] LEVEL_MID = LEVEL_W'(1);

endpackage
`default_nettype wire

// ===== rtl/core/dvfs_pick_in_if.sv =====
// Interface: input channel carrying one ready-queue entry word.
`default_nettype none
interface dvfs_pick_in_if;
    logic                              valid;
    logic                              ready;
    logic [dvfs_pick_pkg::REM_W-1:0]   remaining_us;
    logic                              last;

    modport source (output valid, output remaining_us, output last, input ready);
    modport sink   (input valid, input remaining_us, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dvfs_pick_out_if.sv =====
// Interface: output channel carrying one decision result word.
`default_nettype none
interface dvfs_pick_out_if;
    logic                                valid;
    logic                                ready;
    logic [dvfs_pick_pkg::LEVEL_W-1:0]   freq_level;
    logic [dvfs_pick_pkg::OSLOT_W-1:0]   chosen_slot;

    modport source (output valid, output freq_level, output chosen_slot, input ready);
    modport sink   (input valid, input freq_level, input chosen_slot, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dvfs_level_and_srtf_pick.sv =====
// Top level: DVFS frequency level and shortest-remaining-first slot pick.
// Throughput: one entry word per cycle, sustained while the result side does not stall, including across decisions.
// Result path: accepting the last entry word snapshots the decision into the decision
//   register; from there the level compare stage loads the output register once it is
//   free (empty, or its result is being taken).
// Backpressure on the result side stalls the input only once both the decision
//   register and the output register are full.
// Reset: rst_n asynchronous active low; clears accumulators, valids and loads register defaults.
`default_nettype none
module dvfs_level_and_srtf_pick (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_we,
    input  wire logic [dvfs_pick_pkg::CFG_IX_W-1:0]      cfg_index,
    input  wire logic [dvfs_pick_pkg::CFG_W-1:0]         cfg_data,
    dvfs_pick_in_if.sink                                 entry,
    dvfs_pick_out_if.source                              result
);

    localparam int REM_W    = dvfs_pick_pkg::REM_W;
    localparam int PCT_W    = dvfs_pick_pkg::PCT_W;
    localparam int LEVEL_W  = dvfs_pick_pkg::LEVEL_W;
    localparam int CNT_W    = dvfs_pick_pkg::CNT_W;
    localparam int SLOT_W   = dvfs_pick_pkg::SLOT_W;
    localparam int SUM_W    = dvfs_pick_pkg::SUM_W;
    localparam int SUM100_W = dvfs_pick_pkg::SUM100_W;
    localparam int UTIL_W   = dvfs_pick_pkg::UTIL_W;
    localparam int LONG_W   = dvfs_pick_pkg::LONG_W;
    localparam int SC_W     = dvfs_pick_pkg::SC_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [REM_W-1:0]   short_thr_reg;
    logic [PCT_W-1:0]   util_thr_reg;
    logic [REM_W-1:0]   long_thr_reg;
    logic [REM_W-1:0]   window_reg;
    logic [LEVEL_W-1:0] top_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_thr_reg <= dvfs_pick_pkg::SHORT_THR_RST;
            util_thr_reg  <= dvfs_pick_pkg::UTIL_THR_RST;
            long_thr_reg  <= dvfs_pick_pkg::LONG_THR_RST;
            window_reg    <= dvfs_pick_pkg::WINDOW_RST;
            top_level_reg <= dvfs_pick_pkg::TOP_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dvfs_pick_pkg::CFG_SHORT_THR: short_thr_reg <= cfg_data[REM_W-1:0];
                dvfs_pick_pkg::CFG_UTIL_THR:  util_thr_reg  <= cfg_data[PCT_W-1:0];
                dvfs_pick_pkg::CFG_LONG_THR:  long_thr_reg  <= cfg_data[REM_W-1:0];
                dvfs_pick_pkg::CFG_WINDOW:    window_reg    <= cfg_data[REM_W-1:0];
                dvfs_pick_pkg::CFG_TOP_LEVEL: top_level_reg <= cfg_data[LEVEL_W-1:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: decision stage -> output register
    // ------------------------------------------------------------------
    logic dec_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic dec_free;
    logic in_fire;
    logic in_last_fire;

    assign out_free     = !out_valid_reg || result.ready;
    assign dec_free     = !dec_valid_reg || out_free;
    assign entry.ready  = dec_free;
    assign in_fire      = entry.valid && entry.ready;
    assign in_last_fire = in_fire && entry.last;

    // ------------------------------------------------------------------
    // Accumulate stage: sum, counts and first strict minimum
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]  sum_reg,      sum_next;
    logic [CNT_W-1:0]  cnt_reg,      cnt_next;
    logic [CNT_W-1:0]  short_reg,    short_next;
    logic [REM_W-1:0]  best_rem_reg, best_rem_next;
    logic [SLOT_W-1:0] best_slot_reg, best_slot_next;

    always_comb
    begin
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        short_next     = short_reg;
        best_rem_next  = best_rem_reg;
        best_slot_next = best_slot_reg;
        // words past the limit are dropped but still may close the decision
        if (cnt_reg < CNT_W'(dvfs_pick_pkg::MAX_ENTRIES))
        begin
            if (cnt_reg == '0 || entry.remaining_us < best_rem_reg)
            begin
                best_rem_next  = entry.remaining_us;
                best_slot_next = cnt_reg[SLOT_W-1:0];
            end
            sum_next = sum_reg + SUM_W'(entry.remaining_us);
            if (entry.remaining_us <= short_thr_reg)
                short_next = short_reg + CNT_W'(1);
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            short_reg     <= '0;
            best_rem_reg  <= '0;
            best_slot_reg <= '0;
        end
        else if (in_last_fire)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            short_reg     <= '0;
            best_rem_reg  <= '0;
            best_slot_reg <= '0;
        end
        else if (in_fire)
        begin
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            short_reg     <= short_next;
            best_rem_reg  <= best_rem_next;
            best_slot_reg <= best_slot_next;
        end
    end

    // ------------------------------------------------------------------
    // Decision register: snapshot of the closed decision
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]  dec_sum_reg;
    logic [CNT_W-1:0]  dec_cnt_reg;
    logic [CNT_W-1:0]  dec_short_reg;
    logic [SLOT_W-1:0] dec_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dec_valid_reg <= 1'b0;
        else if (dec_free)
            dec_valid_reg <= in_last_fire;
    end

    always_ff @(posedge clk)
    begin
        if (in_last_fire)
        begin
            dec_sum_reg   <= sum_next;
            dec_cnt_reg   <= cnt_next;
            dec_short_reg <= short_next;
            dec_slot_reg  <= best_slot_next;
        end
    end

    // ------------------------------------------------------------------
    // Level select: divisions recast as cross-multiplied compares
    // ------------------------------------------------------------------
    logic [REM_W-1:0]    window_eff;
    logic [SC_W-1:0]     short_x5;
    logic [SC_W-1:0]     cnt_x3;
    logic [SUM100_W-1:0] sum_x100;
    logic [UTIL_W-1:0]   util_x_win;
    logic [LONG_W-1:0]   long_x_cnt;
    logic                many_short;
    logic                busy;
    logic                long_avg;
    logic [LEVEL_W-1:0]  level_next;

    always_comb
    begin
        window_eff = (window_reg < dvfs_pick_pkg::WINDOW_MIN) ?
                     dvfs_pick_pkg::WINDOW_MIN : window_reg;
        short_x5   = SC_W'(dec_short_reg) * SC_W'(5);
        cnt_x3     = SC_W'(dec_cnt_reg) * SC_W'(3);
        sum_x100   = SUM100_W'(dec_sum_reg) * SUM100_W'(100);
        util_x_win = UTIL_W'(util_thr_reg) * UTIL_W'(window_eff);
        long_x_cnt = LONG_W'(long_thr_reg) * LONG_W'(dec_cnt_reg);
        many_short = short_x5 > cnt_x3;
        // threshold at or above full scale can never be exceeded
        busy       = (util_thr_reg < dvfs_pick_pkg::PCT_FULL) &&
                     (sum_x100 > SUM100_W'(util_x_win));
        long_avg   = LONG_W'(dec_sum_reg) > long_x_cnt;
        if (many_short || busy)
            level_next = top_level_reg;
        else if (long_avg)
            level_next = dvfs_pick_pkg::LEVEL_LOW;
        else
            level_next = dvfs_pick_pkg::LEVEL_MID;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0]                level_reg;
    logic [dvfs_pick_pkg::OSLOT_W-1:0] slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= dec_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && dec_valid_reg)
        begin
            level_reg <= level_next;
            slot_reg  <= dvfs_pick_pkg::OSLOT_W'(dec_slot_reg);
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.freq_level  = level_reg;
    assign result.chosen_slot = slot_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(dvfs_pick_pkg::MAX_ENTRIES))
        else $error("entry count past limit");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_last_fire |=> (cnt_reg == '0) && (sum_reg == '0) && (short_reg == '0))
        else $error("accumulators not cleared after last word");

    a_last_to_dec: assert property (@(posedge clk) disable iff (!rst_n)
        in_last_fire |=> dec_valid_reg)
        else $error("closed decision not captured");

    a_dec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid_reg && !out_free) |=> dec_valid_reg && $stable(dec_sum_reg)
                                         && $stable(dec_slot_reg))
        else $error("decision register lost while output stalled");

    a_dec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid_reg && out_free) |=> out_valid_reg)
        else $error("decision not moved to output register");

endmodule
`default_nettype wire
